[rtl/bup16_pkg.sv]
package bup16_pkg;

  // coordinate and fixed-point widths
  localparam int POS_W  = 13;   // 2*pos+1 for a 12-bit position
  localparam int FRAC_W = 16;
  localparam int ONE_Q16  = 65536;
  localparam int HALF_Q16 = 32768;

  // datapath widths
  localparam int PIX_W = 32;
  localparam int WT_W  = 33;    // product of two Q16 factors, up to 2**32
  localparam int MUL_W = 34;    // operand width of the shared multiplier
  localparam int ACC_W = 64;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd3;

  // commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_DIVSTART,
    ST_DIVWAIT,
    ST_MAP,
    ST_WEIGHT,
    ST_MAC,
    ST_OUT
  } seq_state_t;

endpackage

[rtl/bup16_ram.sv]
module bup16_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/bup16_div.sv]
module bup16_div #(
  parameter int NUM_W = 36,
  parameter int DV_W  = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DV_W-1:0]  divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DV_W-1:0]  rem;
  logic [DV_W-1:0]  rem_next;
  logic [NUM_W-1:0] quo;
  logic [DV_W:0]    trial;
  logic             fits;

  // restoring division, one quotient bit per cycle, MSB first
  always_comb begin
    trial    = {rem, quo[NUM_W-1]};
    fits     = trial >= {1'b0, divisor};
    rem_next = fits ? DV_W'(trial - {1'b0, divisor}) : DV_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(NUM_W);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (cnt != '0) begin
      quo <= {quo[NUM_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

[rtl/bilinear_upsample_q16_unit.sv]
// Channel   Handshake                Payload
// cmd       cmd_valid / cmd_stall    command, row, col, pixel_value
// res       res_valid / res_stall    result_value
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// For a query, with NUM_W = 13 + input size width + 16, each axis runs one bit-serial
// division of NUM_W steps, then one shared multiplier forms four weights and four
// products, one store read each. Reset clears control and sets all four size registers
// to 1; the plane store is not cleared. A stalled result holds in the output register
// while the next word may already be taken; a query finishing behind it waits.
module bilinear_upsample_q16_unit #(
  parameter int MAX_IN_HEIGHT = 64,
  parameter int MAX_IN_WIDTH  = 64,
  parameter int MAX_OUT_DIM   = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  logic                             command,
  input  logic [11:0]                      row,
  input  logic [11:0]                      col,
  input  logic signed [31:0]               pixel_value,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic signed [31:0]               result_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bup16_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bup16_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int MAX_IN = (MAX_IN_HEIGHT > MAX_IN_WIDTH) ? MAX_IN_HEIGHT : MAX_IN_WIDTH;
  localparam int IN_W   = $clog2(MAX_IN + 1);
  localparam int PROD_W = bup16_pkg::POS_W + IN_W;
  localparam int NUM_W  = PROD_W + bup16_pkg::FRAC_W;
  localparam int OD_W   = $clog2(MAX_OUT_DIM + 1);
  localparam int DV_W   = OD_W + 1;
  localparam int RA_W   = (MAX_IN_HEIGHT > 1) ? $clog2(MAX_IN_HEIGHT) : 1;
  localparam int CA_W   = (MAX_IN_WIDTH > 1) ? $clog2(MAX_IN_WIDTH) : 1;
  localparam int DEPTH  = MAX_IN_HEIGHT * MAX_IN_WIDTH;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW     = bup16_pkg::FRAC_W;
  localparam int MW     = bup16_pkg::MUL_W;

  bup16_pkg::seq_state_t state, state_next;

  // size registers
  logic [6:0]  in_height, in_width;
  logic [12:0] out_height, out_width;
  logic [IN_W-1:0] ih, iw, ins_sel;
  logic [OD_W-1:0] oh, ow, outs_sel;

  // query context
  logic        axis;
  logic [2:0]  step;
  logic [11:0] row_q, col_q;
  logic [11:0] pos_sel;
  logic [RA_W-1:0] r0, r1;
  logic [CA_W-1:0] k0, k1;
  logic [FW-1:0]   wr, wk;
  logic [bup16_pkg::WT_W-1:0] wt [4];
  logic signed [bup16_pkg::ACC_W-1:0] prod, acc;

  // shared multiplier
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] mul_p;
  logic signed [bup16_pkg::ACC_W-1:0] mul_lo;
  logic [FW:0] rf, cf;
  logic [1:0]  wsel;

  // divider
  logic             div_start, div_done;
  logic [NUM_W-1:0] quotient;

  // axis mapping
  logic             q_ge;
  logic [NUM_W-1:0] q_d;
  logic [PROD_W-1:0] bq, insx, bm, b1m;
  logic [FW-1:0]     wm;

  // store
  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [31:0]   st_rdata;
  logic [RA_W-1:0] ri;
  logic [CA_W-1:0] ci;

  logic cmd_acc, out_load;

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != bup16_pkg::ST_IDLE);
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign out_load  = !res_valid || !res_stall;

  // zero acts as 1, oversize saturates
  always_comb begin
    ih = (in_height == '0) ? IN_W'(1) :
         (32'(in_height) > MAX_IN_HEIGHT) ? IN_W'(MAX_IN_HEIGHT) : IN_W'(in_height);
    iw = (in_width == '0) ? IN_W'(1) :
         (32'(in_width) > MAX_IN_WIDTH) ? IN_W'(MAX_IN_WIDTH) : IN_W'(in_width);
    oh = (out_height == '0) ? OD_W'(1) :
         (32'(out_height) > MAX_OUT_DIM) ? OD_W'(MAX_OUT_DIM) : OD_W'(out_height);
    ow = (out_width == '0) ? OD_W'(1) :
         (32'(out_width) > MAX_OUT_DIM) ? OD_W'(MAX_OUT_DIM) : OD_W'(out_width);
    ins_sel  = axis ? iw : ih;
    outs_sel = axis ? ow : oh;
    pos_sel  = axis ? col_q : row_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_height  <= 7'd1;
      in_width   <= 7'd1;
      out_height <= 13'd1;
      out_width  <= 13'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bup16_pkg::REG_IN_HEIGHT:  in_height  <= cfg_data[6:0];
        bup16_pkg::REG_IN_WIDTH:   in_width   <= cfg_data[6:0];
        bup16_pkg::REG_OUT_HEIGHT: out_height <= cfg_data;
        bup16_pkg::REG_OUT_WIDTH:  out_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  // plane store
  assign st_we = cmd_acc && (command == bup16_pkg::CMD_LOAD) &&
                 (32'(row) < MAX_IN_HEIGHT) && (32'(col) < MAX_IN_WIDTH);
  assign st_waddr = AW'(row[RA_W-1:0]) * AW'(MAX_IN_WIDTH) + AW'(col[CA_W-1:0]);

  always_comb begin
    ri = step[1] ? r1 : r0;
    ci = step[0] ? k1 : k0;
    st_raddr = AW'(ri) * AW'(MAX_IN_WIDTH) + AW'(ci);
  end

  bup16_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (st_we),
    .wr_addr(st_waddr),
    .wr_data(pixel_value),
    .rd_addr(st_raddr),
    .rd_data(st_rdata)
  );

  assign div_start = (state == bup16_pkg::ST_DIVSTART);

  bup16_div #(
    .NUM_W(NUM_W),
    .DV_W (DV_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend({prod[PROD_W-1:0], {FW{1'b0}}}),
    .divisor ({outs_sel, 1'b0}),
    .done    (div_done),
    .quotient(quotient)
  );

  // source position: floor, clamp at the edges, zero weight there
  always_comb begin
    insx = PROD_W'(ins_sel);
    q_ge = quotient >= NUM_W'(bup16_pkg::HALF_Q16);
    q_d  = quotient - NUM_W'(bup16_pkg::HALF_Q16);
    bq   = q_d[NUM_W-1:FW];
    if (!q_ge) begin
      bm = '0;
      wm = '0;
    end else if (bq >= insx) begin
      bm = insx - 1'b1;
      wm = '0;
    end else begin
      bm = bq;
      wm = (bq + 1'b1 >= insx) ? '0 : q_d[FW-1:0];
    end
    b1m = (bm + 1'b1 < insx) ? bm + 1'b1 : bm;
  end

  // shared multiplier operand select
  always_comb begin
    rf    = step[1] ? {1'b0, wr} : (FW+1)'(bup16_pkg::ONE_Q16) - {1'b0, wr};
    cf    = step[0] ? {1'b0, wk} : (FW+1)'(bup16_pkg::ONE_Q16) - {1'b0, wk};
    wsel  = step[1:0] - 2'd1;
    mul_a = '0;
    mul_b = '0;
    case (state)
      bup16_pkg::ST_PROD: begin
        mul_a = $signed(MW'({pos_sel, 1'b1}));
        mul_b = $signed(MW'(ins_sel));
      end
      bup16_pkg::ST_WEIGHT: begin
        mul_a = $signed(MW'(rf));
        mul_b = $signed(MW'(cf));
      end
      bup16_pkg::ST_MAC: begin
        mul_a = $signed({{(MW-32){st_rdata[31]}}, st_rdata});
        mul_b = $signed(MW'(wt[wsel]));
      end
      default: ;
    endcase
    mul_p  = mul_a * mul_b;
    mul_lo = mul_p[bup16_pkg::ACC_W-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bup16_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bup16_pkg::ST_IDLE: begin
        if (cmd_acc && command == bup16_pkg::CMD_QUERY) begin
          state_next = bup16_pkg::ST_PROD;
        end
      end
      bup16_pkg::ST_PROD:     state_next = bup16_pkg::ST_DIVSTART;
      bup16_pkg::ST_DIVSTART: state_next = bup16_pkg::ST_DIVWAIT;
      bup16_pkg::ST_DIVWAIT: begin
        if (div_done) begin
          state_next = bup16_pkg::ST_MAP;
        end
      end
      bup16_pkg::ST_MAP: begin
        state_next = axis ? bup16_pkg::ST_WEIGHT : bup16_pkg::ST_PROD;
      end
      bup16_pkg::ST_WEIGHT: begin
        if (step == 3'd3) begin
          state_next = bup16_pkg::ST_MAC;
        end
      end
      bup16_pkg::ST_MAC: begin
        if (step == 3'd5) begin
          state_next = bup16_pkg::ST_OUT;
        end
      end
      bup16_pkg::ST_OUT: begin
        if (out_load) begin
          state_next = bup16_pkg::ST_IDLE;
        end
      end
      default: state_next = bup16_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis <= 1'b0;
      step <= '0;
    end else begin
      case (state)
        bup16_pkg::ST_IDLE: begin
          axis <= 1'b0;
          step <= '0;
        end
        bup16_pkg::ST_MAP: begin
          axis <= 1'b1;
        end
        bup16_pkg::ST_WEIGHT: begin
          step <= (step == 3'd3) ? 3'd0 : step + 3'd1;
        end
        bup16_pkg::ST_MAC: begin
          step <= step + 3'd1;
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      bup16_pkg::ST_IDLE: begin
        if (cmd_acc) begin
          row_q <= row;
          col_q <= col;
        end
      end
      bup16_pkg::ST_PROD: begin
        prod <= mul_lo;
      end
      bup16_pkg::ST_MAP: begin
        if (axis) begin
          k0 <= CA_W'(bm);
          k1 <= CA_W'(b1m);
          wk <= wm;
        end else begin
          r0 <= RA_W'(bm);
          r1 <= RA_W'(b1m);
          wr <= wm;
        end
      end
      bup16_pkg::ST_WEIGHT: begin
        wt[step[1:0]] <= mul_lo[bup16_pkg::WT_W-1:0];
      end
      bup16_pkg::ST_MAC: begin
        // the registered store read is multiplied into prod, then summed into acc
        if (step >= 3'd1 && step <= 3'd4) begin
          prod <= mul_lo;
        end
        if (step == 3'd2) begin
          acc <= prod;
        end else if (step >= 3'd3) begin
          acc <= acc + prod;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == bup16_pkg::ST_OUT && out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bup16_pkg::ST_OUT && out_load) begin
      result_value <= acc[bup16_pkg::ACC_W-1:32];
    end
  end

endmodule

[tb/sv/bilinear_upsample_q16_unit_chk.sv]
module bilinear_upsample_q16_unit_chk #(
  parameter int MAX_IN_HEIGHT = 64,
  parameter int MAX_IN_WIDTH  = 64,
  parameter int MAX_OUT_DIM   = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  input  logic                             cmd_stall,
  input  logic                             command,
  input  logic [11:0]                      row,
  input  logic [11:0]                      col,
  input  logic signed [31:0]               pixel_value,
  input  logic                             res_valid,
  input  logic                             res_stall,
  input  logic signed [31:0]               result_value,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [bup16_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bup16_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               mismatches,
  output int                               pending
);

  localparam longint FRAC_MASK = 64'hFFFF;

  logic signed [31:0] plane_copy [MAX_IN_HEIGHT*MAX_IN_WIDTH];
  logic [6:0]         in_h_reg;
  logic [6:0]         in_w_reg;
  logic [12:0]        out_h_reg;
  logic [12:0]        out_w_reg;
  logic signed [31:0] pending_pixels [$];
  int                 mismatch_total = 0;

  // zero acts as one, anything above the maximum saturates
  function automatic longint active_size(longint v, longint mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  // half-pixel source position of one output coordinate, floored and edge clamped
  function automatic void source_pos(input longint pos, input longint outs,
                                     input longint ins, output longint base,
                                     output longint weight);
    longint q;
    q = ((2 * pos + 1) * ins * bup16_pkg::ONE_Q16) / (2 * outs) - bup16_pkg::HALF_Q16;
    if (q < 0) begin
      base = 0;
      weight = 0;
    end else begin
      base = q >>> bup16_pkg::FRAC_W;
      weight = q & FRAC_MASK;
    end
    if (base >= ins) begin
      base = ins - 1;
      weight = 0;
    end
    if (base + 1 >= ins) weight = 0;
  endfunction

  function automatic logic signed [31:0] interp_pixel(logic [11:0] r, logic [11:0] k);
    longint ih, iw, oh, ow;
    longint r0, r1, k0, k1, wr, wk;
    longint p00, p01, p10, p11, upper, lower, acc;
    ih = active_size(in_h_reg, MAX_IN_HEIGHT);
    iw = active_size(in_w_reg, MAX_IN_WIDTH);
    oh = active_size(out_h_reg, MAX_OUT_DIM);
    ow = active_size(out_w_reg, MAX_OUT_DIM);
    source_pos(r, oh, ih, r0, wr);
    source_pos(k, ow, iw, k0, wk);
    r1 = (r0 + 1 < ih) ? r0 + 1 : r0;
    k1 = (k0 + 1 < iw) ? k0 + 1 : k0;
    p00 = plane_copy[r0 * MAX_IN_WIDTH + k0];
    p01 = plane_copy[r0 * MAX_IN_WIDTH + k1];
    p10 = plane_copy[r1 * MAX_IN_WIDTH + k0];
    p11 = plane_copy[r1 * MAX_IN_WIDTH + k1];
    upper = p00 * (bup16_pkg::ONE_Q16 - wk) + p01 * wk;
    lower = p10 * (bup16_pkg::ONE_Q16 - wk) + p11 * wk;
    acc = upper * (bup16_pkg::ONE_Q16 - wr) + lower * wr;
    // upper half of the accumulator is the floor of acc / 2**32
    return acc[63:32];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatch_total++;
  endtask

  always @(posedge clk) begin : watch
    logic signed [31:0] want;
    if (rst) begin
      in_h_reg = 7'd1;
      in_w_reg = 7'd1;
      out_h_reg = 13'd1;
      out_w_reg = 13'd1;
      pending_pixels.delete();
    end else begin
      // compare before taking a new query: a word out now belongs to an older one
      if (res_valid && !res_stall) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("result_value %0d with no query waiting", result_value));
        end else begin
          want = pending_pixels.pop_front();
          if (result_value !== want)
            report_mismatch($sformatf("result_value got %0d expected %0d",
                                      result_value, want));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bup16_pkg::REG_IN_HEIGHT:  in_h_reg = cfg_data[6:0];
          bup16_pkg::REG_IN_WIDTH:   in_w_reg = cfg_data[6:0];
          bup16_pkg::REG_OUT_HEIGHT: out_h_reg = cfg_data;
          bup16_pkg::REG_OUT_WIDTH:  out_w_reg = cfg_data;
          default: ;
        endcase
      end
      if (cmd_valid && !cmd_stall) begin
        if (command == bup16_pkg::CMD_LOAD) begin
          if (row < MAX_IN_HEIGHT && col < MAX_IN_WIDTH)
            plane_copy[row * MAX_IN_WIDTH + col] = pixel_value;
        end else begin
          pending_pixels.push_back(interp_pixel(row, col));
        end
      end
    end
    pending <= pending_pixels.size();
    mismatches <= mismatch_total;
  end

endmodule

[tb/sv/bilinear_upsample_q16_unit_tb.sv]
module bilinear_upsample_q16_unit_tb;

  localparam int STORE_H        = 64;
  localparam int STORE_W        = 64;
  localparam int OUT_MAX        = 4096;
  localparam int SETTLE_CYCLES  = 150;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int IDX_W          = bup16_pkg::CFG_IDX_W;
  localparam int DATA_W         = bup16_pkg::CFG_DATA_W;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cmd_valid = 1'b0;
  logic                   cmd_stall;
  logic                   command = bup16_pkg::CMD_LOAD;
  logic [11:0]            row = '0;
  logic [11:0]            col = '0;
  logic signed [31:0]     pixel_value = '0;
  logic                   res_valid;
  logic                   res_stall = 1'b0;
  logic signed [31:0]     result_value;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [IDX_W-1:0]       cfg_index = bup16_pkg::REG_IN_HEIGHT;
  logic [DATA_W-1:0]      cfg_data = '0;

  int mismatches;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int eff_h = 1, eff_w = 1, eff_oh = 1, eff_ow = 1;
  bit loaded [STORE_H*STORE_W];

  bilinear_upsample_q16_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command      (command),
    .row          (row),
    .col          (col),
    .pixel_value  (pixel_value),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .result_value (result_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  bilinear_upsample_q16_unit_chk pixel_check (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command      (command),
    .row          (row),
    .col          (col),
    .pixel_value  (pixel_value),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .result_value (result_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // end the run if no word moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("bilinear_upsample_q16_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int in_size(logic [12:0] v, int mx);
    logic [6:0] m;
    m = v[6:0];
    if (m == 0) return 1;
    if (m > mx) return mx;
    return int'(m);
  endfunction

  function automatic int out_size(logic [12:0] v);
    if (v == 0) return 1;
    if (v > OUT_MAX) return OUT_MAX;
    return int'(v);
  endfunction

  function automatic logic signed [31:0] rand_pixel();
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // idle the sender cycle by cycle at random, then hold the word until taken
  task automatic send_word(input logic c, input logic [11:0] r, input logic [11:0] k,
                           input logic signed [31:0] p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    command <= c;
    row <= r;
    col <= k;
    pixel_value <= p;
    do @(posedge clk); while (cmd_stall);
    if (c == bup16_pkg::CMD_LOAD && r < STORE_H && k < STORE_W) loaded[r * STORE_W + k] = 1'b1;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // wait out every outstanding query, then let the block go quiet
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sizes(input logic [12:0] h, input logic [12:0] w,
                           input logic [12:0] oh, input logic [12:0] ow);
    logic [IDX_W-1:0] stray_idx;
    stray_idx = IDX_W'(bup16_pkg::REG_OUT_WIDTH + $urandom_range(1, 4));
    write_reg(bup16_pkg::REG_IN_HEIGHT, h);
    write_reg(bup16_pkg::REG_IN_WIDTH, w);
    write_reg(bup16_pkg::REG_OUT_HEIGHT, oh);
    write_reg(bup16_pkg::REG_OUT_WIDTH, ow);
    // index past the last register: must leave the sizes alone
    write_reg(stray_idx, DATA_W'($urandom));
    cfg_valid <= 1'b0;
    eff_h = in_size(h, STORE_H);
    eff_w = in_size(w, STORE_W);
    eff_oh = out_size(oh);
    eff_ow = out_size(ow);
  endtask

  // load every pixel of the active plane that has never been written
  task automatic fill_plane();
    for (int r = 0; r < eff_h; r++)
      for (int k = 0; k < eff_w; k++)
        if (!loaded[r * STORE_W + k])
          send_word(bup16_pkg::CMD_LOAD, 12'(r), 12'(k), rand_pixel());
  endtask

  task automatic random_word();
    logic [11:0] r;
    logic [11:0] k;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      if ($urandom_range(0, 9) < 7) begin
        r = 12'($urandom_range(0, eff_oh - 1));
        k = 12'($urandom_range(0, eff_ow - 1));
      end else begin
        r = 12'($urandom_range(0, 4095));
        k = 12'($urandom_range(0, 4095));
      end
      send_word(bup16_pkg::CMD_QUERY, r, k, $urandom);
    end else begin
      sel = $urandom_range(0, 9);
      if (sel < 8) begin
        r = 12'($urandom_range(0, eff_h - 1));
        k = 12'($urandom_range(0, eff_w - 1));
      end else if (sel < 9) begin
        r = 12'($urandom_range(0, STORE_H - 1));
        k = 12'($urandom_range(0, STORE_W - 1));
      end else begin
        r = 12'($urandom_range(0, 4095));
        k = 12'($urandom_range(0, 4095));
      end
      send_word(bup16_pkg::CMD_LOAD, r, k, rand_pixel());
    end
  endtask

  task automatic run_phase(input logic [12:0] h, input logic [12:0] w,
                           input logic [12:0] oh, input logic [12:0] ow, input int n);
    drain();
    set_sizes(h, w, oh, ow);
    fill_plane();
    repeat (n) random_word();
  endtask

  initial begin
    send_idle_pct = 7;
    recv_stall_pct = 74;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sizes straight out of reset
    send_word(bup16_pkg::CMD_LOAD, 0, 0, 32'h7FFF_FFFF);
    send_word(bup16_pkg::CMD_QUERY, 0, 0, $urandom);
    send_word(bup16_pkg::CMD_QUERY, 12'hFFF, 12'hFFF, $urandom);

    drain();
    set_sizes(2, 3, 5, 7);
    send_word(bup16_pkg::CMD_LOAD, 0, 0, 32'h8000_0000);
    send_word(bup16_pkg::CMD_LOAD, 0, 1, 32'h7FFF_FFFF);
    send_word(bup16_pkg::CMD_LOAD, 0, 2, 32'hFFFF_FFFF);
    send_word(bup16_pkg::CMD_LOAD, 1, 0, 32'h0);
    send_word(bup16_pkg::CMD_LOAD, 1, 1, 32'h7FFF_FFFF);
    send_word(bup16_pkg::CMD_LOAD, 1, 2, 32'h8000_0000);
    // loads outside the store: drop them, they must not alias into the plane
    send_word(bup16_pkg::CMD_LOAD, 0, 64, 32'h5A5A_5A5A);
    send_word(bup16_pkg::CMD_LOAD, 64, 0, 32'h5A5A_5A5A);
    send_word(bup16_pkg::CMD_LOAD, 12'hFFF, 12'hFFF, 32'h5A5A_5A5A);
    send_word(bup16_pkg::CMD_QUERY, 0, 0, $urandom);
    send_word(bup16_pkg::CMD_QUERY, 4, 6, $urandom);
    send_word(bup16_pkg::CMD_QUERY, 2, 3, $urandom);
    send_word(bup16_pkg::CMD_QUERY, 12'hFFF, 0, $urandom);
    send_word(bup16_pkg::CMD_QUERY, 0, 12'hFFF, $urandom);
    send_word(bup16_pkg::CMD_QUERY, 1, 1, $urandom);

    run_phase(4, 4, 8, 8, 150);
    run_phase(1, 64, 1, 4096, 150);
    run_phase(64, 1, 4096, 1, 150);

    send_idle_pct = 74;
    recv_stall_pct = 7;
    run_phase(0, 0, 0, 0, 100);
    run_phase(16, 16, 3, 5, 150);
    run_phase(5, 13'h1FFF, 13'h1FFF, 4097, 150);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_phase(8, 64, 4096, 4096, 150);
    run_phase(3, 7, 4095, 2, 150);
    run_phase(13'($urandom_range(1, 8)), 13'($urandom_range(1, 64)),
              13'($urandom_range(1, 300)), 13'($urandom_range(1, 300)), 100);

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("bilinear_upsample_q16_unit: match");
    end else begin
      $display("bilinear_upsample_q16_unit: mismatch");
    end
    $finish;
  end

endmodule
